### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Plain invariant, checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

### rtl/cpurq_pkg.sv
// Package with the shared types and defaults of the ready-queue scheduler.
`timescale 1ns / 1ps
package cpurq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam logic [15:0] QUANTUM_RESET = 16'd10;

   localparam logic [1:0] POL_PRIO = 2'd0;
   localparam logic [1:0] POL_SRTF = 2'd1;
   localparam logic [1:0] POL_RR   = 2'd2;

   localparam logic REQ_ARRIVE = 1'b0;
   localparam logic REQ_DONE   = 1'b1;

   localparam logic CSR_POLICY  = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] arrival;
      logic [15:0] total;
      logic [15:0] remaining;
      logic [7:0]  prio;
   } entry_type;

   typedef struct packed {
      logic        free_seen;
      logic        best_valid;
      logic [31:0] best_key;
      entry_type   best_entry;
   } link_type;

endpackage

### rtl/cpurq_cell.sv
// One ready-table slot: holds an entry and passes the running search to its neighbor.
`timescale 1ns / 1ps
module cpurq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            policy,
   input  logic                  ins_en,
   input  logic                  take_en,
   input  cpurq_pkg::entry_type  wr_entry,
   input  cpurq_pkg::link_type   fwd_in,
   output cpurq_pkg::link_type   fwd_out,
   input  logic                  back_in,
   output logic                  back_out,
   output logic                  occupied
);

   logic                 valid_ff, valid_in;
   cpurq_pkg::entry_type entry_ff, entry_in;
   cpurq_pkg::link_type  fwd_ff, fwd_in_nxt;
   logic                 back_ff;
   logic [31:0]          key;
   logic                 won;

   always_comb begin
      case (policy)
         cpurq_pkg::POL_PRIO: key = {24'd0, entry_ff.prio};
         cpurq_pkg::POL_SRTF: key = {16'd0, entry_ff.remaining};
         default:             key = entry_ff.arrival;
      endcase
   end

   // strict compare keeps the earlier slot on a tie
   assign won = valid_ff && (!fwd_in.best_valid || key < fwd_in.best_key);

   always_comb begin
      fwd_in_nxt.free_seen  = fwd_in.free_seen | ~valid_ff;
      fwd_in_nxt.best_valid = fwd_in.best_valid | valid_ff;
      fwd_in_nxt.best_key   = won ? key : fwd_in.best_key;
      fwd_in_nxt.best_entry = won ? entry_ff : fwd_in.best_entry;
   end

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ins_en && !valid_ff && !fwd_in.free_seen) begin
         valid_in = 1'b1;
         entry_in = wr_entry;
      end else if (take_en && won && !back_in) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fwd_ff   <= '0;
         back_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         fwd_ff   <= fwd_in_nxt;
         back_ff  <= won | back_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign fwd_out  = fwd_ff;
   assign back_out = back_ff;
   assign occupied = valid_ff;

endmodule

### rtl/cpu_ready_queue_scheduler.sv
// Top level of the three-policy CPU ready-queue scheduler.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one scheduling event: an arrival (req_type 0) or the
//   completion of the running process (req_type 1). A beat is taken when
//   req_valid is high and req_stall is low.
//   rsp_* returns one beat per event describing the process now running,
//   the table fill and a drop flag; it holds while rsp_stall is high.
//   csr_* writes policy (index 0) or the round-robin quantum (index 1);
//   csr_ready is always high. Write registers only while no event is in flight.
// Ready table and flow:
//   The ready table is a row of QUEUE_DEPTH cells. Each cell registers the
//   free-slot flag and the best key so far and hands them on, and a reverse
//   chain marks which cell holds the winner. The block waits in its scan state
//   until both chains have settled, acts on the event in its execute state and
//   raises rsp_valid in its done state. One event is in flight at a time;
//   req_stall stays high from acceptance until the response beat is taken,
//   and during reset.
// Reset:
//   Clears the running process (CPU idle), all slot valid bits, the count,
//   and sets policy to priority and the quantum to 10.
`include "assert_macros.svh"

module cpu_ready_queue_scheduler #(
   parameter int QUEUE_DEPTH = cpurq_pkg::QUEUE_DEPTH_DEF,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [15:0]       req_proc_ident,
   input  logic [31:0]       req_arrival_time,
   input  logic [15:0]       req_total_burst,
   input  logic [7:0]        req_priority_req,
   input  logic [31:0]       req_event_time,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_out_valid,
   output logic [15:0]       rsp_out_proc_ident,
   output logic [31:0]       rsp_out_arrival_time,
   output logic [15:0]       rsp_out_total_burst,
   output logic [31:0]       rsp_out_start_time,
   output logic [31:0]       rsp_out_end_time,
   output logic [15:0]       rsp_out_remaining_burst,
   output logic [7:0]        rsp_out_priority,
   output logic [CNT_W-1:0]  rsp_out_queue_count,
   output logic              rsp_out_dropped,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int SCAN_CYC = 2 * QUEUE_DEPTH;
   localparam int SCAN_W   = $clog2(SCAN_CYC + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EXEC = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type             state_ff;
   logic [SCAN_W-1:0]     scan_ff;
   logic [1:0]            policy_ff;
   logic [15:0]           quantum_ff;

   // captured event
   logic                  type_ff;
   cpurq_pkg::entry_type  arr_ff;
   logic [31:0]           now_ff;

   // running process
   logic                  cur_valid_ff;
   cpurq_pkg::entry_type  cur_ff;
   logic [31:0]           cur_start_ff, cur_end_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  dropped_ff;

   cpurq_pkg::link_type   fwd [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH:0]  back;
   logic [QUEUE_DEPTH-1:0] occ;

   logic                  ins_en, take_en;
   cpurq_pkg::entry_type  wr_entry, run_entry;
   logic                  preempt;
   logic [31:0]           ran;
   logic [15:0]           rem_left, run_len;
   logic [32:0]           end_sum;
   logic [31:0]           run_end;
   logic                  do_run, do_idle, do_drop;

   assign fwd[0]            = '0;
   assign back[QUEUE_DEPTH] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cpurq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .policy   (policy_ff),
         .ins_en   (ins_en),
         .take_en  (take_en),
         .wr_entry (wr_entry),
         .fwd_in   (fwd[i]),
         .fwd_out  (fwd[i+1]),
         .back_in  (back[i+1]),
         .back_out (back[i]),
         .occupied (occ[i])
      );
   end

   // preemption and time-run arithmetic
   always_comb begin
      case (policy_ff)
         cpurq_pkg::POL_PRIO: preempt = arr_ff.prio < cur_ff.prio;
         cpurq_pkg::POL_SRTF: preempt = arr_ff.total <= cur_ff.remaining;
         default:             preempt = 1'b0;
      endcase
      ran      = (now_ff >= cur_start_ff) ? now_ff - cur_start_ff : 32'd0;
      rem_left = (ran >= {16'd0, cur_ff.remaining}) ? 16'd0
                                                   : cur_ff.remaining - ran[15:0];
   end

   // decide the action of the event
   always_comb begin
      ins_en   = 1'b0;
      take_en  = 1'b0;
      do_run   = 1'b0;
      do_idle  = 1'b0;
      do_drop  = 1'b0;
      wr_entry = arr_ff;
      run_entry = arr_ff;
      if (state_ff == S_EXEC) begin
         if (type_ff == cpurq_pkg::REQ_ARRIVE) begin
            if (!cur_valid_ff) begin
               do_run = 1'b1;
            end else if (!fwd[QUEUE_DEPTH].free_seen) begin
               do_drop = 1'b1;
            end else if (preempt) begin
               ins_en   = 1'b1;
               wr_entry = cur_ff;
               wr_entry.remaining = rem_left;
               do_run   = 1'b1;
            end else begin
               ins_en = 1'b1;
            end
         end else begin
            if (fwd[QUEUE_DEPTH].best_valid) begin
               take_en   = 1'b1;
               do_run    = 1'b1;
               run_entry = fwd[QUEUE_DEPTH].best_entry;
            end else begin
               do_idle = 1'b1;
            end
         end
      end
   end

   // end time: round robin caps the slice at the quantum, then saturate
   always_comb begin
      run_len = run_entry.remaining;
      if (policy_ff[1] && quantum_ff < run_entry.remaining) begin
         run_len = quantum_ff;
      end
      end_sum = {1'b0, now_ff} + {17'd0, run_len};
      run_end = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         policy_ff    <= cpurq_pkg::POL_PRIO;
         quantum_ff   <= cpurq_pkg::QUANTUM_RESET;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
         cur_start_ff <= '0;
         cur_end_ff   <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cpurq_pkg::CSR_POLICY:  policy_ff  <= csr_wdata[1:0];
               cpurq_pkg::CSR_QUANTUM: quantum_ff <= csr_wdata;
               default:                ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  scan_ff  <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // hold until both chains have settled
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == SCAN_W'(SCAN_CYC - 1)) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               dropped_ff <= do_drop;
               if (do_run) begin
                  cur_valid_ff <= 1'b1;
                  cur_ff       <= run_entry;
                  cur_start_ff <= now_ff;
                  cur_end_ff   <= run_end;
               end else if (do_idle) begin
                  cur_valid_ff <= 1'b0;
                  cur_ff       <= '0;
                  cur_start_ff <= '0;
                  cur_end_ff   <= '0;
               end
               if (ins_en) begin
                  count_ff <= count_ff + 1'b1;
               end else if (take_en) begin
                  count_ff <= count_ff - 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // capture the event beat
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         type_ff           <= req_type;
         arr_ff.id         <= req_proc_ident;
         arr_ff.arrival    <= req_arrival_time;
         arr_ff.total      <= req_total_burst;
         arr_ff.remaining  <= req_total_burst;
         arr_ff.prio       <= req_priority_req;
         now_ff            <= req_event_time;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_DONE);

   assign rsp_out_valid           = cur_valid_ff;
   assign rsp_out_proc_ident      = cur_ff.id;
   assign rsp_out_arrival_time    = cur_ff.arrival;
   assign rsp_out_total_burst     = cur_ff.total;
   assign rsp_out_start_time      = cur_start_ff;
   assign rsp_out_end_time        = cur_end_ff;
   assign rsp_out_remaining_burst = cur_ff.remaining;
   assign rsp_out_priority        = cur_ff.prio;
   assign rsp_out_queue_count     = count_ff;
   assign rsp_out_dropped         = dropped_ff;

   `ASSERT_ALWAYS(a_count_match, $countones(occ) == int'(count_ff), "count differs from slots")
   `ASSERT_ALWAYS(a_count_bound, int'(count_ff) <= QUEUE_DEPTH, "count beyond depth")
   `ASSERT_IMPLIES(a_drop_full, rsp_valid && rsp_out_dropped, int'(rsp_out_queue_count) == QUEUE_DEPTH, "drop with free slot")
   `ASSERT_IMPLIES(a_idle_zero, rsp_valid && !rsp_out_valid, rsp_out_proc_ident == 16'd0 && rsp_out_end_time == 32'd0, "idle result not cleared")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the CPU ready-queue scheduler.
`timescale 1ns / 1ps
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = cpurq_pkg::REQ_ARRIVE;
   logic [15:0] req_proc_ident = '0;
   logic [31:0] req_arrival_time = '0;
   logic [15:0] req_total_burst = '0;
   logic [7:0]  req_priority_req = '0;
   logic [31:0] req_event_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_out_valid;
   logic [15:0] rsp_out_proc_ident;
   logic [31:0] rsp_out_arrival_time;
   logic [15:0] rsp_out_total_burst;
   logic [31:0] rsp_out_start_time;
   logic [31:0] rsp_out_end_time;
   logic [15:0] rsp_out_remaining_burst;
   logic [7:0]  rsp_out_priority;
   logic [4:0]  rsp_out_queue_count;
   logic        rsp_out_dropped;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = cpurq_pkg::CSR_POLICY;
   logic [15:0] csr_wdata = '0;

   cpu_ready_queue_scheduler dut (.*);

   always #10 clock = ~clock;

   // One event beat and one schedule beat.
   typedef struct packed {
      logic        kind;
      logic [15:0] pid;
      logic [31:0] arr;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [31:0] now;
   } event_type;

   typedef struct packed {
      logic        running;
      logic [15:0] pid;
      logic [31:0] arr;
      logic [15:0] total;
      logic [31:0] start;
      logic [31:0] stop;
      logic [15:0] remain;
      logic [7:0]  prio;
      logic [4:0]  count;
      logic        dropped;
   } sched_type;

   // Scheduler shadow state.
   logic [1:0]  sh_policy;
   logic [15:0] sh_quantum;
   sched_type   sh_cpu;
   logic        tbl_valid [16];
   cpurq_pkg::entry_type tbl_entry [16];
   logic [4:0]  tbl_count;

   sched_type   sched_queue [$];
   int          error_count = 0;
   longint      cycle_count = 0;
   logic        quiet = 1'b0;   // no random idling in the last stretch
   logic        hold_active = 1'b0;   // long receiver hold-off in progress
   event        hold_go;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic logic [31:0] end_of(input logic [31:0] start,
                                         input logic [15:0] rem);
      logic [15:0] len;
      logic [32:0] sum;
      len = rem;
      if (sh_policy >= cpurq_pkg::POL_RR && sh_quantum < len) len = sh_quantum;
      sum = {1'b0, start} + {17'd0, len};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic void dispatch(input cpurq_pkg::entry_type e,
                                    input logic [31:0] now);
      sh_cpu.running = 1'b1;
      sh_cpu.pid = e.id;
      sh_cpu.arr = e.arrival;
      sh_cpu.total = e.total;
      sh_cpu.remain = e.remaining;
      sh_cpu.prio = e.prio;
      sh_cpu.start = now;
      sh_cpu.stop = end_of(now, e.remaining);
   endfunction

   function automatic logic [31:0] key_of(input cpurq_pkg::entry_type e);
      if (sh_policy == cpurq_pkg::POL_PRIO) return {24'd0, e.prio};
      if (sh_policy == cpurq_pkg::POL_SRTF) return {16'd0, e.remaining};
      return e.arrival;
   endfunction

   // Work out the schedule beat that one event produces.
   function automatic sched_type schedule_event(input event_type ev);
      cpurq_pkg::entry_type incoming, bumped;
      int        free_idx, best;
      logic      preempt, drop;
      logic [31:0] ran, bk;
      drop = 1'b0;
      incoming = '{id: ev.pid, arrival: ev.arr, total: ev.burst,
                   remaining: ev.burst, prio: ev.prio};
      if (ev.kind == cpurq_pkg::REQ_ARRIVE) begin
         if (!sh_cpu.running) begin
            dispatch(incoming, ev.now);
         end else begin
            free_idx = -1;
            for (int i = 15; i >= 0; i--) if (!tbl_valid[i]) free_idx = i;
            if (sh_policy == cpurq_pkg::POL_PRIO) preempt = ev.prio < sh_cpu.prio;
            else if (sh_policy == cpurq_pkg::POL_SRTF) preempt = ev.burst <= sh_cpu.remain;
            else preempt = 1'b0;
            if (free_idx < 0) begin
               drop = 1'b1;
            end else if (preempt) begin
               ran = ev.now >= sh_cpu.start ? ev.now - sh_cpu.start : 32'd0;
               bumped = '{id: sh_cpu.pid, arrival: sh_cpu.arr, total: sh_cpu.total,
                          remaining: (ran >= sh_cpu.remain) ? 16'd0
                                     : sh_cpu.remain - ran[15:0],
                          prio: sh_cpu.prio};
               tbl_valid[free_idx] = 1'b1;
               tbl_entry[free_idx] = bumped;
               tbl_count++;
               dispatch(incoming, ev.now);
            end else begin
               tbl_valid[free_idx] = 1'b1;
               tbl_entry[free_idx] = incoming;
               tbl_count++;
            end
         end
      end else begin
         best = -1;
         bk = '0;
         for (int i = 0; i < 16; i++)
            if (tbl_valid[i] && (best < 0 || key_of(tbl_entry[i]) < bk)) begin
               best = i;
               bk = key_of(tbl_entry[i]);
            end
         if (best < 0) begin
            sh_cpu = '0;
         end else begin
            tbl_valid[best] = 1'b0;
            tbl_count--;
            dispatch(tbl_entry[best], ev.now);
         end
      end
      sh_cpu.count = tbl_count;
      sh_cpu.dropped = drop;
      return sh_cpu;
   endfunction

   task automatic wait_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   // Drive one event beat and hold it until it is taken.
   task automatic send_event(input event_type ev);
      req_valid <= 1'b1;
      {req_type, req_proc_ident, req_arrival_time, req_total_burst,
       req_priority_req, req_event_time} <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sched_queue.push_back(schedule_event(ev));
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         wait_cycles($urandom_range(1, 13));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sched_queue.size() != 0) @(negedge clock);
      wait_cycles(40);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == cpurq_pkg::CSR_POLICY) sh_policy = val[1:0];
      else sh_quantum = val;
   endtask

   function automatic event_type random_event(input logic [31:0] now);
      event_type ev;
      ev.kind = ($urandom_range(0, 99) < 55) ? cpurq_pkg::REQ_ARRIVE
                                             : cpurq_pkg::REQ_DONE;
      ev.pid = 16'($urandom);
      ev.arr = ($urandom_range(0, 9) == 0) ? $urandom : now - $urandom_range(0, 50);
      case ($urandom_range(0, 3))
         0: ev.burst = 16'($urandom);
         1: ev.burst = 16'(16'hFFFF - $urandom_range(0, 3));
         default: ev.burst = 16'($urandom_range(1, 40));
      endcase
      ev.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      ev.now = now;
      return ev;
   endfunction

   // Compare each schedule beat with the oldest prediction.
   always @(posedge clock) begin
      sched_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sched_queue.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = sched_queue.pop_front();
            if (rsp_out_valid !== want.running)
               report_mismatch("out_valid", rsp_out_valid, want.running);
            if (rsp_out_proc_ident !== want.pid)
               report_mismatch("proc_ident", rsp_out_proc_ident, want.pid);
            if (rsp_out_arrival_time !== want.arr)
               report_mismatch("arrival_time", rsp_out_arrival_time, want.arr);
            if (rsp_out_total_burst !== want.total)
               report_mismatch("total_burst", rsp_out_total_burst, want.total);
            if (rsp_out_start_time !== want.start)
               report_mismatch("start_time", rsp_out_start_time, want.start);
            if (rsp_out_end_time !== want.stop)
               report_mismatch("end_time", rsp_out_end_time, want.stop);
            if (rsp_out_remaining_burst !== want.remain)
               report_mismatch("remaining", rsp_out_remaining_burst, want.remain);
            if (rsp_out_priority !== want.prio)
               report_mismatch("priority", rsp_out_priority, want.prio);
            if (rsp_out_queue_count !== want.count)
               report_mismatch("queue_count", rsp_out_queue_count, want.count);
            if (rsp_out_dropped !== want.dropped)
               report_mismatch("dropped", rsp_out_dropped, want.dropped);
         end
      end
   end

   // Long receiver hold-off, counted here once requested.
   initial begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (300) @(negedge clock);
      hold_active <= 1'b0;
   end

   // Receiver stall: random bursts, plus the long hold-off.
   always @(negedge clock) begin
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: stop with a failure once the cycle count passes its limit.
   always @(posedge clock) begin
      if (cycle_count > 500000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Directed rows: expected beat typed in where it is plain, else predicted.
   typedef struct {
      event_type ev;
      logic      typed;
      sched_type want;
   } row_type;

   initial begin
      row_type     rows [$];
      sched_type   got;
      logic [31:0] now;
      event_type   ev;
      sh_policy = cpurq_pkg::POL_PRIO;
      sh_quantum = cpurq_pkg::QUANTUM_RESET;
      sh_cpu = '0;
      tbl_count = '0;
      for (int i = 0; i < 16; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_entry[i] = '0;
      end
      wait_cycles(6);
      reset <= 1'b0;
      @(negedge clock);

      // Completion while idle stays idle; then an extreme arrival starts at once.
      rows.push_back('{'{cpurq_pkg::REQ_DONE, 16'h0, 32'h0, 16'h0, 8'h0, 32'h5},
                       1'b1, '0});
      rows.push_back('{'{cpurq_pkg::REQ_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                         8'hFF, 32'hFFFF_FFF0}, 1'b1,
                       '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0,
                         32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 5'd0, 1'b0}});
      // Process id zero preempts with priority zero; clock going backward
      // makes the time run zero.
      rows.push_back('{'{cpurq_pkg::REQ_ARRIVE, 16'h0, 32'h0, 16'h1, 8'h0, 32'h10},
                       1'b0, '0});
      // Fill the table to full so later arrivals get dropped.
      for (int i = 0; i < 16; i++)
         rows.push_back('{'{cpurq_pkg::REQ_ARRIVE, 16'(i + 1), 32'(i), 16'(i + 2),
                           8'(200 - i), 32'(20 + i)}, 1'b0, '0});
      rows.push_back('{'{cpurq_pkg::REQ_ARRIVE, 16'h55, 32'h0, 16'h1, 8'h0, 32'h40},
                       1'b0, '0});
      for (int i = 0; i < 3; i++)
         rows.push_back('{'{cpurq_pkg::REQ_DONE, 16'h0, 32'h0, 16'h0, 8'h0,
                           32'(50 + i)}, 1'b0, '0});

      foreach (rows[r]) begin
         send_event(rows[r].ev);
         if (rows[r].typed) begin
            got = sched_queue[$];
            if (got !== rows[r].want) report_mismatch("table row", r, 0);
         end
      end
      drain();

      // Random phases across policy and quantum settings, extremes included.
      now = 32'd1000;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_SRTF));
               write_csr(cpurq_pkg::CSR_QUANTUM, 16'd1);
            end
            1: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_RR));
               write_csr(cpurq_pkg::CSR_QUANTUM, 16'hFFFF);
            end
            2: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'd3);
               write_csr(cpurq_pkg::CSR_QUANTUM, 16'd0);
            end
            3: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_PRIO));
               write_csr(cpurq_pkg::CSR_QUANTUM, 16'd7);
            end
            4: write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_RR));
            5: write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_SRTF));
            6: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_PRIO));
               now = 32'hFFFF_F000;
            end
            default: begin
               write_csr(cpurq_pkg::CSR_POLICY, 16'(cpurq_pkg::POL_RR));
               write_csr(cpurq_pkg::CSR_QUANTUM, 16'($urandom_range(1, 65535)));
            end
         endcase
         if (ph == 7) quiet = 1'b1;
         if (ph == 2) -> hold_go;  // let the block back up against its input
         for (int n = 0; n < 150; n++) begin
            now = now + $urandom_range(0, 30);
            ev = random_event(now);
            if ($urandom_range(0, 19) == 0) ev.now = now - $urandom_range(1, 100);
            send_event(ev);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
